FILE: rtl/mandelbrot_escape_time_assert.svh
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_assert.svh
// assertion macros shared by the escape time block
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// same cycle implication, checked outside reset
`define MET_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escape time assertion failed");

// next cycle implication, checked outside reset
`define MET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escape time assertion failed");

`endif

FILE: rtl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// types, constants and fixed point helpers of the escape time block
// ----------------------------------------------------------------------------
`default_nettype none

package met_pkg;

  localparam int WIDTH_PX_DEF   = 1024;
  localparam int HEIGHT_PX_DEF  = 1024;
  localparam int ITER_LIMIT_DEF = 1024;

  localparam int FRAC_BITS   = 28;
  localparam int JOB_Q_DEPTH = 2;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // configuration register indexes
  localparam logic [2:0] CFG_ORIGIN_RE  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_IM  = 3'd1;
  localparam logic [2:0] CFG_ZOOM_SCALE = 3'd2;
  localparam logic [2:0] CFG_STEP_X     = 3'd3;
  localparam logic [2:0] CFG_STEP_Y     = 3'd4;
  localparam logic [2:0] CFG_ESC_RAD_SQ = 3'd5;
  localparam logic [2:0] CFG_MAX_ITER   = 3'd6;

  typedef struct packed {
    logic [9:0] column;
    logic [9:0] row;
  } met_in_t;

  typedef struct packed {
    logic [19:0] pixel_index;
    logic [10:0] iterations;
    logic        inside_set;
  } met_out_t;

  typedef struct packed {
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        zoom_scale;
    logic [30:0]        step_x;
    logic [30:0]        step_y;
    logic [30:0]        escape_radius_sq;
    logic [10:0]        cap;
  } met_cfg_t;

  typedef struct packed {
    logic [19:0]        pixel_index;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } met_job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL1,
    F_OFFS,
    F_MUL2,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SAT,
    B_UPD,
    B_DONE
  } back_state_t;

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    logic [32:0] upper;
    upper = v[63:31];
    if ((&upper) || !(|upper)) begin
      return v[31:0];
    end
    return v[63] ? Q_MIN : Q_MAX;
  endfunction

  // full product back to q4.28, floor rounding, saturated
  function automatic logic signed [31:0] q_shift_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_BITS;
    return sat_q(s);
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? Q_MIN : Q_MAX;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? Q_MIN : Q_MAX;
    end
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/met_front.sv
// ----------------------------------------------------------------------------
// met_front
// accepts a pixel and maps it to the complex point c, one item at a time
// ----------------------------------------------------------------------------
`default_nettype none

module met_front #(
  parameter int WIDTH_PX  = met_pkg::WIDTH_PX_DEF,
  parameter int HEIGHT_PX = met_pkg::HEIGHT_PX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire met_pkg::met_cfg_t cfg,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire met_pkg::met_in_t  in_data,
  output logic                   q_push,
  input  wire logic              q_full,
  output met_pkg::met_job_t      q_wdata
);
  import met_pkg::*;

  localparam int HalfW = WIDTH_PX / 2;
  localparam int HalfH = HEIGHT_PX / 2;

  front_state_t       state_r, state_nxt;
  logic signed [31:0] a_re_r, a_im_r;
  logic signed [63:0] prod_re_r, prod_im_r;
  logic [19:0]        pidx_r;
  logic signed [31:0] b_re, b_im;
  logic               take;

  assign take = in_push && !in_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (take) state_nxt = F_MUL1;
      F_MUL1: state_nxt = F_OFFS;
      F_OFFS: state_nxt = F_MUL2;
      F_MUL2: state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_full = (state_r != F_IDLE);
    q_push  = (state_r == F_PUSH) && !q_full;
  end

  // shared multiplier operand: step first, zoom second
  always_comb begin
    if (state_r == F_MUL1) begin
      b_re = $signed({1'b0, cfg.step_x});
      b_im = $signed({1'b0, cfg.step_y});
    end else begin
      b_re = $signed({1'b0, cfg.zoom_scale});
      b_im = $signed({1'b0, cfg.zoom_scale});
    end
  end

  always_comb begin
    q_wdata.pixel_index = pidx_r;
    q_wdata.re          = q_shift_sat(prod_re_r);
    q_wdata.im          = q_shift_sat(prod_im_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (take) begin
          a_re_r <= $signed({22'b0, in_data.column}) - 32'(HalfW);
          a_im_r <= $signed({22'b0, in_data.row}) - 32'(HalfH);
          pidx_r <= 20'(in_data.row) * 20'(WIDTH_PX) + 20'(in_data.column);
        end
      end
      F_MUL1, F_MUL2: begin
        prod_re_r <= a_re_r * b_re;
        prod_im_r <= a_im_r * b_im;
      end
      F_OFFS: begin
        a_re_r <= add_sat(sat_q(prod_re_r), cfg.origin_re);
        a_im_r <= add_sat(sat_q(prod_im_r), cfg.origin_im);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/met_fifo.sv
// ----------------------------------------------------------------------------
// met_fifo
// short job queue between the mapping front and the iteration back
// ----------------------------------------------------------------------------
`default_nettype none

module met_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire met_pkg::met_job_t wdata,
  input  wire logic              pop,
  output logic                   empty,
  output met_pkg::met_job_t      rdata
);
  import met_pkg::*;

  localparam int AW = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
  localparam int CW = $clog2(JOB_Q_DEPTH + 1);

  met_job_t        slot_r [JOB_Q_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(JOB_Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    if (p == AW'(JOB_Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

`default_nettype wire

FILE: rtl/met_iter.sv
// ----------------------------------------------------------------------------
// met_iter
// escape time iteration engine with its result register
// ----------------------------------------------------------------------------
`default_nettype none

module met_iter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire met_pkg::met_cfg_t cfg,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire met_pkg::met_job_t q_rdata,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output met_pkg::met_out_t      out_data
);
  import met_pkg::*;

  back_state_t        state_r, state_nxt;
  logic signed [31:0] re_r, im_r, x_r, y_r;
  logic signed [31:0] x2_r, y2_r, xy_r;
  logic signed [63:0] pxx_r, pyy_r, pxy_r;
  logic [10:0]        n_r;
  logic [19:0]        pidx_r;
  logic               inside_r;
  met_out_t           res_r;
  logic               res_valid_r;
  logic               slot_free, at_cap, escape, res_load;
  logic signed [31:0] mag, x_new, y_new;

  assign slot_free = !res_valid_r || out_pop;
  assign at_cap    = (n_r == cfg.cap);

  always_comb begin
    mag    = add_sat(x2_r, y2_r);
    escape = (mag >= $signed({1'b0, cfg.escape_radius_sq}));
    x_new  = add_sat(sub_sat(x2_r, y2_r), re_r);
    y_new  = add_sat(add_sat(xy_r, xy_r), im_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_MUL;
      B_MUL:  state_nxt = at_cap ? B_DONE : B_SAT;
      B_SAT:  state_nxt = B_UPD;
      B_UPD:  state_nxt = escape ? B_DONE : B_MUL;
      B_DONE: if (slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == B_IDLE) && !q_empty;
    res_load  = (state_r == B_DONE) && slot_free;
    out_empty = !res_valid_r;
    out_data  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (out_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          pidx_r <= q_rdata.pixel_index;
          re_r   <= q_rdata.re;
          im_r   <= q_rdata.im;
          x_r    <= q_rdata.re;
          y_r    <= q_rdata.im;
          n_r    <= '0;
        end
      end
      B_MUL: begin
        inside_r <= 1'b1;
        pxx_r    <= x_r * x_r;
        pyy_r    <= y_r * y_r;
        pxy_r    <= x_r * y_r;
      end
      B_SAT: begin
        x2_r <= q_shift_sat(pxx_r);
        y2_r <= q_shift_sat(pyy_r);
        xy_r <= q_shift_sat(pxy_r);
      end
      B_UPD: begin
        if (escape) begin
          inside_r <= 1'b0;
        end else begin
          x_r <= x_new;
          y_r <= y_new;
          n_r <= n_r + 1'b1;
        end
      end
      B_DONE: begin
        if (res_load) begin
          res_r.pixel_index <= pidx_r;
          res_r.iterations  <= n_r;
          res_r.inside_set  <= inside_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape time evaluator: pixel in, iteration count and inside flag out
// ----------------------------------------------------------------------------
// A pixel is taken in one beat by a mapping front that turns it into the point
// c through two shared signed 32x32 multipliers (step, then zoom). The job
// enters a two-entry queue from F_PUSH after the states F_MUL1, F_OFFS and
// F_MUL2, waiting there while the queue is full, and the front takes a new
// pixel only once the last one is pushed, holding in_full high meanwhile.
// The iteration engine pops a job and passes through B_MUL, B_SAT and B_UPD
// on every update z = z^2 + c (squaring products, saturation, escape test and
// update); a pixel leaves the back when it escapes after n updates or when it
// reaches the cap, clamped to ITER_LIMIT. That loop sets the sustained rate;
// the front maps the next pixels while the engine iterates. A finished result
// waits in an output register; while it is not popped, the engine holds its
// next finished result, the queue fills and in_full rises.
`default_nettype none

module mandelbrot_escape_time #(
  parameter int WIDTH_PX   = met_pkg::WIDTH_PX_DEF,
  parameter int HEIGHT_PX  = met_pkg::HEIGHT_PX_DEF,
  parameter int ITER_LIMIT = met_pkg::ITER_LIMIT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_wdata,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire met_pkg::met_in_t in_data,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output met_pkg::met_out_t     out_data
);
  import met_pkg::*;

  logic signed [31:0] x_off_r, y_off_r;
  logic [30:0]        zoom_r, step_x_r, step_y_r, rad_r;
  logic [10:0]        max_it_r;
  met_cfg_t           cfg;
  logic               q_push, q_full, q_pop, q_empty;
  met_job_t           q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r  <= '0;
      y_off_r  <= '0;
      zoom_r   <= 31'd268435456;
      step_x_r <= 31'd805306;
      step_y_r <= 31'd805306;
      rad_r    <= 31'd1073741824;
      max_it_r <= 11'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_RE:  x_off_r  <= cfg_wdata;
        CFG_ORIGIN_IM:  y_off_r  <= cfg_wdata;
        CFG_ZOOM_SCALE: zoom_r   <= cfg_wdata[30:0];
        CFG_STEP_X:     step_x_r <= cfg_wdata[30:0];
        CFG_STEP_Y:     step_y_r <= cfg_wdata[30:0];
        CFG_ESC_RAD_SQ: rad_r    <= cfg_wdata[30:0];
        CFG_MAX_ITER:   max_it_r <= cfg_wdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.origin_re        = x_off_r;
    cfg.origin_im        = y_off_r;
    cfg.zoom_scale       = zoom_r;
    cfg.step_x           = step_x_r;
    cfg.step_y           = step_y_r;
    cfg.escape_radius_sq = rad_r;
    cfg.cap              = (32'(max_it_r) > 32'(ITER_LIMIT)) ? 11'(ITER_LIMIT) : max_it_r;
  end

  met_front #(
    .WIDTH_PX (WIDTH_PX),
    .HEIGHT_PX(HEIGHT_PX)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .q_push (q_push),
    .q_full (q_full),
    .q_wdata(q_wdata)
  );

  met_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .full (q_full),
    .wdata(q_wdata),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_rdata)
  );

  met_iter u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_rdata  (q_rdata),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

`include "mandelbrot_escape_time_assert.svh"

  `MET_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full)
  `MET_ASSERT_IMPL(a_inside_at_cap, !out_empty && out_data.inside_set, out_data.iterations == cfg.cap)
  `MET_ASSERT_IMPL(a_escape_below_cap, !out_empty && !out_data.inside_set, out_data.iterations < cfg.cap)
  `MET_ASSERT_NEXT(a_pop_frees_queue, q_pop && !q_push, !q_full)

endmodule

`default_nettype wire
